@@ src/hjo_pkg.sv @@
package hjo_pkg;

    // fixed field widths
    localparam int IDX_W   = 31;
    localparam int PHASE_W = 8;
    localparam int OUT_W   = 16;

    // parameter defaults
    localparam int PHASE_BITS_DEFAULT    = 8;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int PHASE_COUNT_RESET = 8;

    // modulo walks the index two bits per cycle
    localparam int MOD_CYCLES = (IDX_W + 1) / 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SEED,
        ST_DIGIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic seed;
        logic digit_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic v_zero;
    } status_t;

endpackage

@@ src/halton_jitter_offset_top.sv @@
// flow: an accepted sample passes ST_MOD, ST_SEED, ST_DIGIT, ST_DIV and ST_OUT to out_valid;
// a new transaction is taken only after ST_OUT has loaded the last result (out_stall can hold it)
// steps: two-bit-per-cycle modulo, a base-3 digit loop over the sample number's digits (1 to 6 at
// default parameters) and a two-bit-per-cycle divider, one item in flight at a time
// reset: phase count returns to 8 (masked to PHASE_BITS), no result pending, block idle
module halton_jitter_offset_top #(
    parameter int PHASE_BITS    = hjo_pkg::PHASE_BITS_DEFAULT,
    parameter int FRACTION_BITS = hjo_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hjo_pkg::PHASE_W-1:0]      cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [hjo_pkg::IDX_W-1:0]        frame_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [hjo_pkg::OUT_W-1:0] jitter_x,
    output logic signed [hjo_pkg::OUT_W-1:0] jitter_y
);
    import hjo_pkg::*;

    cmd_t    cmd;
    status_t status;

    hjo_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    hjo_datapath #(
        .PHASE_BITS    (PHASE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .frame_index (frame_index),
        .cmd         (cmd),
        .status      (status),
        .jitter_x    (jitter_x),
        .jitter_y    (jitter_y)
    );

endmodule

@@ src/hjo_ctrl.sv @@
module hjo_ctrl #(
    parameter int FRACTION_BITS = hjo_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output hjo_pkg::cmd_t   cmd,
    input  hjo_pkg::status_t status
);
    import hjo_pkg::*;

    localparam int DIV_CYCLES = (FRACTION_BITS + 1) / 2;
    localparam int CNT_MAX    = (MOD_CYCLES > DIV_CYCLES) ? MOD_CYCLES : DIV_CYCLES;
    localparam int CNT_W      = $clog2(CNT_MAX);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                count_next   = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(MOD_CYCLES - 1))
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                // peel base-3 digits until the value runs out
                if (status.v_zero)
                begin
                    cmd.div_init = 1'b1;
                    count_next   = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.digit_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/hjo_datapath.sv @@
module hjo_datapath #(
    parameter int PHASE_BITS    = hjo_pkg::PHASE_BITS_DEFAULT,
    parameter int FRACTION_BITS = hjo_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [hjo_pkg::PHASE_W-1:0]        cfg_wr_data,
    input  logic [hjo_pkg::IDX_W-1:0]          frame_index,
    input  hjo_pkg::cmd_t                      cmd,
    output hjo_pkg::status_t                   status,
    output logic signed [hjo_pkg::OUT_W-1:0]   jitter_x,
    output logic signed [hjo_pkg::OUT_W-1:0]   jitter_y
);
    import hjo_pkg::*;

    localparam int PB    = PHASE_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int DEN_W = PB + 2;
    localparam int QW    = F + (F % 2);
    localparam int MS    = PB + 1;
    localparam int SW    = (F + 1 > OUT_W + 1) ? F + 1 : OUT_W + 1;

    localparam logic [PB+PHASE_W-1:0] PHASE_RESET_EXT = (PB + PHASE_W)'(PHASE_COUNT_RESET);
    localparam logic [PB-1:0]         PHASE_RESET     = PHASE_RESET_EXT[PB-1:0];
    // ceil(2^MS / 3), exact quotient by 3 for any PB-bit value
    localparam logic [PB:0]           MUL3            = (PB + 1)'(((1 << MS) + 2) / 3);
    localparam logic [SW-1:0]         HALF            = SW'(1) << (F - 1);
    localparam logic signed [SW-1:0]  SAT_HI          = SW'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SW-1:0]  SAT_LO          = -SAT_HI - SW'(1);

    logic [PB-1:0]    phase_reg, phase_next;
    logic [IDX_W:0]   idx_reg;
    logic [PB-1:0]    rem_reg;
    logic [PB-1:0]    n_reg;
    logic [PB-1:0]    v_reg;
    logic [DEN_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] drem_reg;
    logic [QW-1:0]    q_reg;
    logic signed [OUT_W-1:0] jitter_x_reg;
    logic signed [OUT_W-1:0] jitter_y_reg;

    logic [PB+PHASE_W-1:0] cfg_ext;
    logic [PB-1:0]    pc_eff;
    logic [PB:0]      t1, t2;
    logic [PB-1:0]    rem_next;
    logic [2*PB:0]    prod;
    logic [PB-1:0]    quot3;
    logic [PB-1:0]    quot3_x3;
    logic [PB-1:0]    digit_full;
    logic [1:0]       digit;
    logic [DEN_W:0]   u1, u2;
    logic             b1, b2;
    logic [DEN_W-1:0] drem_next;
    logic [PB-1:0]    rev;
    logic [PB+F-1:0]  x_wide;
    logic [F-1:0]     x_frac;
    logic [F-1:0]     y_frac;

    function automatic logic signed [OUT_W-1:0] to_offset(input logic [F-1:0] frac);
        logic signed [SW-1:0] val;
        val = $signed(SW'(frac) - HALF);
        if (val > SAT_HI)
        begin
            val = SAT_HI;
        end
        else if (val < SAT_LO)
        begin
            val = SAT_LO;
        end
        return $signed(val[OUT_W-1:0]);
    endfunction

    // config register keeps only the low PHASE_BITS bits
    always_comb
    begin
        cfg_ext    = (PB + PHASE_W)'(cfg_wr_data);
        phase_next = cfg_wr_en ? cfg_ext[PB-1:0] : phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // restoring modulo, two index bits per step
    always_comb
    begin
        pc_eff = (phase_reg == '0) ? PB'(1) : phase_reg;
        t1 = {rem_reg, idx_reg[IDX_W]};
        if (t1 >= {1'b0, pc_eff})
        begin
            t1 = t1 - {1'b0, pc_eff};
        end
        t2 = {t1[PB-1:0], idx_reg[IDX_W-1]};
        if (t2 >= {1'b0, pc_eff})
        begin
            t2 = t2 - {1'b0, pc_eff};
        end
        rem_next = t2[PB-1:0];
    end

    // one base-3 digit per step via reciprocal multiply
    always_comb
    begin
        prod       = (2 * PB + 1)'(v_reg) * (2 * PB + 1)'(MUL3);
        quot3      = prod[2*PB:MS];
        quot3_x3   = quot3 + {quot3[PB-2:0], 1'b0};
        digit_full = v_reg - quot3_x3;
        digit      = digit_full[1:0];
    end

    // long division of num by den, two quotient bits per step
    always_comb
    begin
        u1 = {drem_reg, 1'b0};
        b1 = (u1 >= {1'b0, den_reg});
        if (b1)
        begin
            u1 = u1 - {1'b0, den_reg};
        end
        u2 = {u1[DEN_W-1:0], 1'b0};
        b2 = (u2 >= {1'b0, den_reg});
        if (b2)
        begin
            u2 = u2 - {1'b0, den_reg};
        end
        drem_next = u2[DEN_W-1:0];
    end

    // base 2 is a bit reversal over the phase width
    always_comb
    begin
        for (int i = 0; i < PB; i++)
        begin
            rev[i] = n_reg[PB-1-i];
        end
        x_wide = {rev, {F{1'b0}}};
        x_frac = x_wide[PB+F-1:PB];
        y_frac = q_reg[QW-1:QW-F];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= {1'b0, frame_index};
            rem_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            idx_reg <= {idx_reg[IDX_W-2:0], 2'b00};
            rem_reg <= rem_next;
        end
        if (cmd.seed)
        begin
            n_reg   <= rem_reg + PB'(1);
            v_reg   <= rem_reg + PB'(1);
            num_reg <= '0;
            den_reg <= DEN_W'(1);
        end
        if (cmd.digit_step)
        begin
            v_reg   <= quot3;
            num_reg <= num_reg + {num_reg[DEN_W-2:0], 1'b0} + DEN_W'(digit);
            den_reg <= den_reg + {den_reg[DEN_W-2:0], 1'b0};
        end
        if (cmd.div_init)
        begin
            drem_reg <= num_reg;
            q_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            drem_reg <= drem_next;
            q_reg    <= {q_reg[QW-3:0], b1, b2};
        end
        if (cmd.out_load)
        begin
            jitter_x_reg <= to_offset(x_frac);
            jitter_y_reg <= to_offset(y_frac);
        end
    end

    assign status.v_zero = (v_reg == '0);
    assign jitter_x      = jitter_x_reg;
    assign jitter_y      = jitter_y_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int PHASE_BITS = hjo_pkg::PHASE_BITS_DEFAULT;
    localparam int FRAC_BITS  = hjo_pkg::FRACTION_BITS_DEFAULT;
    localparam int OUT_W      = hjo_pkg::OUT_W;
    localparam int IDX_W      = hjo_pkg::IDX_W;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 60;
    localparam int RANDOM_SETS  = 10;
    localparam int ITEMS_PER_SET = 143;
    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } jitter_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [hjo_pkg::PHASE_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [IDX_W-1:0] frame_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] jitter_x;
    logic signed [OUT_W-1:0] jitter_y;

    logic [IDX_W-1:0] frame_queue[$];
    jitter_pair_t expected_jitter[$];
    logic [PHASE_BITS-1:0] phase_setting = PHASE_BITS'(hjo_pkg::PHASE_COUNT_RESET);
    logic steady_flow = 1'b0;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int frames_sent = 0;
    int pairs_checked = 0;
    int mismatch_count = 0;
    int settings_used = 1;
    int cycle_count = 0;

    halton_jitter_offset_top #(
        .PHASE_BITS   (PHASE_BITS),
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_index(frame_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .jitter_x   (jitter_x),
        .jitter_y   (jitter_y)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // radical inverse of n in the given base, scaled, truncated, minus one half
    function automatic logic signed [OUT_W-1:0] inverse_fixed(int unsigned n,
                                                              int unsigned base);
        longint unsigned num;
        longint unsigned den;
        int unsigned digits_left;
        longint value;
        num = 0;
        den = 1;
        digits_left = n;
        while (digits_left != 0)
        begin
            num = num * base + digits_left % base;
            den = den * base;
            digits_left = digits_left / base;
        end
        value = longint'((num << FRAC_BITS) / den) - (longint'(1) << (FRAC_BITS - 1));
        if (value > 32767)
            value = 32767;
        if (value < -32768)
            value = -32768;
        return value[OUT_W-1:0];
    endfunction

    function automatic jitter_pair_t predict_jitter(logic [IDX_W-1:0] frame);
        jitter_pair_t pair;
        int unsigned cycle_len;
        int unsigned sample;
        cycle_len = (phase_setting == 0) ? 1 : phase_setting;
        sample = (frame % cycle_len) + 1;
        pair.x = inverse_fixed(sample, 2);
        pair.y = inverse_fixed(sample, 3);
        return pair;
    endfunction

    function automatic logic [IDX_W-1:0] pick_frame();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 3))
            0: return IDX_W'($urandom_range(0, 600));
            1: return raw[IDX_W-1:0];
            2: return INDEX_MAX - IDX_W'($urandom_range(0, 300));
            default: return IDX_W'($urandom_range(0, 2 * phase_setting + 2));
        endcase
    endfunction

    // sender: one transaction offered at a time, random gap after each outside steady-flow sets
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            frame_index <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_jitter = {expected_jitter, predict_jitter(frame_index)};
                frames_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (frame_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    frame_index <= frame_queue.pop_front();
                    send_gap <= steady_flow ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result, stalls per transaction, one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        jitter_pair_t want;
        int next_stall;
        int next_hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            next_stall = stall_left;
            next_hold = hold_left;
            if (out_valid && !out_stall)
            begin
                if (expected_jitter.size() == 0)
                begin
                    $error("unexpected transaction: jitter_x %0d jitter_y %0d",
                           jitter_x, jitter_y);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_jitter.pop_front();
                    if (jitter_x !== want.x)
                    begin
                        $error("jitter_x: expected %0d, got %0d", want.x, jitter_x);
                        mismatch_count++;
                    end
                    if (jitter_y !== want.y)
                    begin
                        $error("jitter_y: expected %0d, got %0d", want.y, jitter_y);
                        mismatch_count++;
                    end
                    pairs_checked++;
                end
                next_stall = steady_flow ? 0 : $urandom_range(0, 4);
            end
            else if (out_valid && next_stall > 0)
            begin
                next_stall--;
            end
            if (hold_request && !hold_taken)
            begin
                next_hold = HOLD_CYCLES;
                hold_taken <= 1'b1;
            end
            else if (next_hold > 0)
            begin
                next_hold--;
            end
            stall_left <= next_stall;
            hold_left <= next_hold;
            out_stall <= (next_stall > 0) || (next_hold > 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // wait until every offered frame has produced its checked result
    task automatic drain();
        do
            @(negedge clk);
        while (frame_queue.size() > 0 || in_valid || expected_jitter.size() > 0);
    endtask

    task automatic write_phase(logic [hjo_pkg::PHASE_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= ~value;
        phase_setting = value[PHASE_BITS-1:0];
        settings_used++;
        @(negedge clk);
    endtask

    task automatic add_frame(logic [IDX_W-1:0] frame);
        frame_queue = {frame_queue, frame};
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            add_frame(pick_frame());
    endtask

    initial
    begin
        logic [hjo_pkg::PHASE_W-1:0] sweep[RANDOM_SETS];
        sweep = '{8'd255, 8'd1, 8'd2, 8'd3, 8'd128, 8'd9, 8'd81, 8'd0, 8'd0, 8'd0};
        sweep[8] = $urandom_range(1, 255);
        sweep[9] = $urandom_range(1, 255);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default cycle of eight after reset, extremes of the index
        for (int i = 0; i < 8; i++)
            add_frame(IDX_W'(i));
        add_frame(INDEX_MAX);
        add_frame(IDX_W'(32'h5555_5555));
        add_frame(IDX_W'(32'h2AAA_AAAA));
        drain();

        // written zero behaves as a cycle of one
        write_phase(8'd0);
        add_frame('0);
        add_frame(IDX_W'(12345));
        add_frame(INDEX_MAX);
        drain();

        // longest cycle: largest sample and the smallest six-digit base-3 sample among others
        write_phase(8'd255);
        add_frame('0);
        add_frame(IDX_W'(254));
        add_frame(IDX_W'(241));
        add_frame(IDX_W'(242));
        add_frame(IDX_W'(127));
        add_frame(INDEX_MAX);
        drain();

        write_phase(8'd1);
        add_frame(INDEX_MAX);
        add_frame(IDX_W'(1));
        drain();

        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            write_phase(sweep[s]);
            steady_flow = (s == 2 || s == 6);
            if (s == 4)
                hold_request <= 1'b1;
            queue_random(ITEMS_PER_SET);
            drain();
        end

        steady_flow = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("sent %0d frame indices over %0d phase-count settings, checked %0d pairs",
                 frames_sent, settings_used, pairs_checked);
        $display("including cycles of one and 255, a written zero and a long output hold-off");
        if (mismatch_count == 0 && expected_jitter.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ halton_jitter_offset_top.f @@
src/hjo_pkg.sv
src/hjo_ctrl.sv
src/hjo_datapath.sv
src/halton_jitter_offset_top.sv
tb/testbench.sv
